// ----- hw/rtl/fatlb_pkg.sv -----
// ---------------------------------------------------------------------------
// fatlb_pkg
// Shared sizes, op codes, state type and payload structs of the
// fully associative TLB with timestamp LRU replacement.
// ---------------------------------------------------------------------------
package fatlb_pkg;

    // sizes
    localparam int ENTRIES    = 16;
    localparam int VPN_BITS   = 20;
    localparam int PPN_BITS   = 20;
    localparam int STAMP_BITS = 32;
    localparam int PID_BITS   = 16;
    localparam int OP_BITS    = 2;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);

    // op codes; the fourth code is a no-op
    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FILL   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_INVAL  = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // request item
    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [PID_BITS-1:0] pid;
        logic [VPN_BITS-1:0] vpn;
        logic [PPN_BITS-1:0] ppn;
    } req_t;

    // result item
    typedef struct packed {
        logic                hit;
        logic [PPN_BITS-1:0] phys_page;
    } rsp_t;

    // one entry as stored in the entry memory
    typedef struct packed {
        logic [VPN_BITS-1:0]   tag;
        logic [PPN_BITS-1:0]   frame;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ----- hw/rtl/fatlb_if.sv -----
// ---------------------------------------------------------------------------
// fatlb_if
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface fatlb_req_if;
    logic                           valid;
    logic                           ready;
    logic [fatlb_pkg::OP_BITS-1:0]  op;
    logic [fatlb_pkg::PID_BITS-1:0] pid;
    logic [fatlb_pkg::VPN_BITS-1:0] vpn;
    logic [fatlb_pkg::PPN_BITS-1:0] ppn;

    modport source (output valid, output op, output pid, output vpn, output ppn,
                    input ready);
    modport sink   (input valid, input op, input pid, input vpn, input ppn,
                    output ready);
endinterface

interface fatlb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [fatlb_pkg::PPN_BITS-1:0] phys_page;

    modport source (output valid, output hit, output phys_page, input ready);
    modport sink   (input valid, input hit, input phys_page, output ready);
endinterface

// ----- hw/rtl/fatlb_ram.sv -----
// ---------------------------------------------------------------------------
// fatlb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fatlb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 72
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/fatlb_scan.sv -----
// ---------------------------------------------------------------------------
// fatlb_scan
// Entry memory, valid bits, use clock and the sequencer that scans one entry
// a cycle for tag match or LRU victim and then writes back.
// ---------------------------------------------------------------------------
module fatlb_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fatlb_pkg::req_t                req,
    input  logic [fatlb_pkg::PID_BITS-1:0] current_pid,
    output logic                           res_valid,
    input  logic                           res_ready,
    output fatlb_pkg::rsp_t                res
);

    fatlb_pkg::state_t                   state_reg, state_next;
    logic [fatlb_pkg::OP_BITS-1:0]       op_reg, op_next;
    logic [fatlb_pkg::VPN_BITS-1:0]      vpn_reg, vpn_next;
    logic [fatlb_pkg::PPN_BITS-1:0]      ppn_reg, ppn_next;
    logic [fatlb_pkg::CNT_BITS-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                                rd_pend_reg, rd_pend_next;
    logic [fatlb_pkg::IDX_BITS-1:0]      rd_idx_reg, rd_idx_next;
    logic                                found_reg, found_next;
    logic [fatlb_pkg::IDX_BITS-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [fatlb_pkg::PPN_BITS-1:0]      tgt_frame_reg, tgt_frame_next;
    logic [fatlb_pkg::STAMP_BITS-1:0]    best_stamp_reg, best_stamp_next;
    logic [fatlb_pkg::STAMP_BITS-1:0]    clock_reg, clock_next;
    logic [fatlb_pkg::ENTRIES-1:0]       valid_reg, valid_next;

    logic                                ram_wr_en;
    logic [fatlb_pkg::IDX_BITS-1:0]      ram_wr_addr;
    fatlb_pkg::entry_t                   ram_wr_entry;
    logic                                ram_rd_en;
    logic [fatlb_pkg::IDX_BITS-1:0]      ram_rd_addr;
    logic [fatlb_pkg::ENTRY_BITS-1:0]    ram_rd_data;
    fatlb_pkg::entry_t                   rd_entry;

    logic                                any_free;
    logic [fatlb_pkg::IDX_BITS-1:0]      free_idx;
    logic                                is_hit;

    fatlb_ram #(
        .DEPTH (fatlb_pkg::ENTRIES),
        .WIDTH (fatlb_pkg::ENTRY_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = fatlb_pkg::entry_t'(ram_rd_data);

    // lowest free entry
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = fatlb_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = fatlb_pkg::IDX_BITS'(i);
            end
        end
    end

    assign is_hit    = found_reg && (op_reg == fatlb_pkg::OP_LOOKUP);
    assign req_ready = (state_reg == fatlb_pkg::ST_IDLE);
    assign res_valid = (state_reg == fatlb_pkg::ST_FINISH);
    assign res.hit       = is_hit;
    assign res.phys_page = is_hit ? tgt_frame_reg : '0;

    // sequencer: next state, scan evaluation, write-back
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        vpn_next        = vpn_reg;
        ppn_next        = ppn_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_frame_next  = tgt_frame_reg;
        best_stamp_next = best_stamp_reg;
        clock_next      = clock_reg;
        valid_next      = valid_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = tgt_idx_reg;
        ram_wr_entry    = '{tag: vpn_reg, frame: ppn_reg,
                            stamp: clock_reg + 1'b1};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = issue_cnt_reg[fatlb_pkg::IDX_BITS-1:0];

        case (state_reg)
            fatlb_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next        = req.op;
                    vpn_next       = req.vpn;
                    ppn_next       = req.ppn;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    state_next     = fatlb_pkg::ST_FINISH;
                    case (req.op)
                        fatlb_pkg::OP_LOOKUP,
                        fatlb_pkg::OP_INVAL:
                        begin
                            if (req.pid == current_pid)
                            begin
                                state_next = fatlb_pkg::ST_SCAN;
                            end
                        end
                        fatlb_pkg::OP_FILL:
                        begin
                            if (any_free)
                            begin
                                found_next   = 1'b1;
                                tgt_idx_next = free_idx;
                            end
                            else
                            begin
                                state_next = fatlb_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = fatlb_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            fatlb_pkg::ST_SCAN:
            begin
                // issue one read a cycle
                if (issue_cnt_reg < fatlb_pkg::CNT_BITS'(fatlb_pkg::ENTRIES))
                begin
                    ram_rd_en      = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = issue_cnt_reg[fatlb_pkg::IDX_BITS-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                // evaluate the entry read last cycle
                if (rd_pend_reg)
                begin
                    if (op_reg == fatlb_pkg::OP_FILL)
                    begin
                        if (!found_reg || (rd_entry.stamp < best_stamp_reg))
                        begin
                            found_next      = 1'b1;
                            tgt_idx_next    = rd_idx_reg;
                            best_stamp_next = rd_entry.stamp;
                        end
                    end
                    else if (!found_reg && valid_reg[rd_idx_reg]
                             && (rd_entry.tag == vpn_reg))
                    begin
                        found_next     = 1'b1;
                        tgt_idx_next   = rd_idx_reg;
                        tgt_frame_next = rd_entry.frame;
                    end
                end
                if (!rd_pend_reg
                    && (issue_cnt_reg == fatlb_pkg::CNT_BITS'(fatlb_pkg::ENTRIES)))
                begin
                    state_next = fatlb_pkg::ST_FINISH;
                end
            end

            fatlb_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = fatlb_pkg::ST_IDLE;
                    case (op_reg)
                        fatlb_pkg::OP_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                ram_wr_en          = 1'b1;
                                ram_wr_entry.frame = tgt_frame_reg;
                                clock_next         = clock_reg + 1'b1;
                            end
                        end
                        fatlb_pkg::OP_FILL:
                        begin
                            ram_wr_en               = 1'b1;
                            valid_next[tgt_idx_reg] = 1'b1;
                            clock_next              = clock_reg + 1'b1;
                        end
                        fatlb_pkg::OP_INVAL:
                        begin
                            if (found_reg)
                            begin
                                valid_next[tgt_idx_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                            ram_wr_en = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = fatlb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fatlb_pkg::ST_IDLE;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            clock_reg     <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            clock_reg     <= clock_next;
            valid_reg     <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        vpn_reg        <= vpn_next;
        ppn_reg        <= ppn_next;
        rd_idx_reg     <= rd_idx_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_frame_reg  <= tgt_frame_next;
        best_stamp_reg <= best_stamp_next;
    end

`ifndef SYNTHESIS
    // memory writes only happen at write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == fatlb_pkg::ST_FINISH) && res_ready)
        else $error("entry write outside write-back");

    // read data only expected while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == fatlb_pkg::ST_SCAN))
        else $error("pending read outside scan");

    // a completed fill leaves its target valid
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fatlb_pkg::ST_FINISH) && res_ready
         && (op_reg == fatlb_pkg::OP_FILL))
        |=> valid_reg[$past(tgt_idx_reg)])
        else $error("fill did not set valid");

    // the use clock only steps by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg))
        |-> (clock_reg == fatlb_pkg::STAMP_BITS'($past(clock_reg) + 1'b1)))
        else $error("use clock jumped");

    // a fill always has a target at write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fatlb_pkg::ST_FINISH) && (op_reg == fatlb_pkg::OP_FILL))
        |-> found_reg)
        else $error("fill without victim");
`endif

endmodule

// ----- hw/rtl/fully_associative_tlb_lru_top.sv -----
// ---------------------------------------------------------------------------
// fully_associative_tlb_lru_top
// Fully associative TLB with timestamp LRU replacement.
// ---------------------------------------------------------------------------
// Usage:
//   req  valid/ready channel of request items: op (lookup, fill, invalidate),
//        pid, vpn, ppn. One result item on rsp for every request item.
//   rsp  valid/ready channel of result items: hit and phys_page (frame on a
//        lookup hit, else zero).
//   cfg_wr_en/cfg_wr_data write current_pid; write only while the block is
//        idle. Lookup and invalidate match only when pid equals it.
// Operation:
//   entries live in a synchronous RAM with a registered read port that is
//   read one entry a cycle. Lookup and invalidate with matching pid, and
//   fill into a full TLB, scan every entry before the result; a fill into
//   a free entry, a pid mismatch or the unused op go straight to the result.
//   One item is in work at a time; the next is taken the cycle after the
//   previous result has moved to the output register.
// Reset: all entries invalid, use clock and current_pid zero; no sweep.
// Stall: a result waits in the output register while rsp.ready is low;
//   the sequencer holds its write-back until the register is free.
// ---------------------------------------------------------------------------
module fully_associative_tlb_lru_top (
    input  logic                           clk,
    input  logic                           rst_n,
    fatlb_req_if.sink                      req,
    fatlb_rsp_if.source                    rsp,
    input  logic                           cfg_wr_en,
    input  logic [fatlb_pkg::PID_BITS-1:0] cfg_wr_data
);

    logic [fatlb_pkg::PID_BITS-1:0] current_pid_reg;
    logic                           rsp_valid_reg;
    fatlb_pkg::rsp_t                rsp_data_reg;
    fatlb_pkg::req_t                req_item;
    fatlb_pkg::rsp_t                res_item;
    logic                           res_valid;
    logic                           res_ready;

    assign req_item = '{op: req.op, pid: req.pid, vpn: req.vpn, ppn: req.ppn};

    fatlb_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req         (req_item),
        .current_pid (current_pid_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res_item)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_pid_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            current_pid_reg <= cfg_wr_data;
        end
    end

    // output register
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_data_reg <= res_item;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.hit       = rsp_data_reg.hit;
    assign rsp.phys_page = rsp_data_reg.phys_page;

endmodule

// ----- tb/fully_associative_tlb_lru_top_test.sv -----
// ---------------------------------------------------------------------------
// fully_associative_tlb_lru_top_test
// Self-checking bench for the fully associative TLB with LRU replacement.
// A shadow copy of the entry store, the use clock and current_pid predicts
// the result item of every accepted request item. A monitor compares each
// result item with the oldest prediction. The run starts with a directed
// sequence and then runs random phases under several current_pid settings,
// with random gaps on both channels, one long receiver hold-off, and a
// final phase without gaps.
// ---------------------------------------------------------------------------
module fully_associative_tlb_lru_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // the unused op code; it must change nothing
    localparam logic [fatlb_pkg::OP_BITS-1:0] OP_NONE = 2'd3;

    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 270;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [fatlb_pkg::PID_BITS-1:0] cfg_wr_data;

    fatlb_req_if req_ch ();
    fatlb_rsp_if rsp_ch ();

    fully_associative_tlb_lru_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow copy of the translation state
    bit                             shadow_valid [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::VPN_BITS-1:0]   shadow_tag   [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::PPN_BITS-1:0]   shadow_frame [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::STAMP_BITS-1:0] shadow_stamp [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::STAMP_BITS-1:0] shadow_clock;
    bit [fatlb_pkg::PID_BITS-1:0]   shadow_pid;

    // request items waiting to be sent, predicted result items
    fatlb_pkg::req_t send_q [$];
    fatlb_pkg::rsp_t predicted_xlat [$];

    // random stimulus shaping
    bit [fatlb_pkg::VPN_BITS-1:0] vpn_pool [64];
    int                           pool_size;
    bit                           gaps_on;
    bit                           hold_trigger;

    // driver and receiver state
    int              send_gap;
    int              rsp_gap;
    int              hold_left;
    bit              hold_seen;
    fatlb_pkg::req_t next_req;
    fatlb_pkg::req_t seen_req;
    fatlb_pkg::rsp_t want;

    // tallies
    int error_count;
    int n_items;
    int n_lookup;
    int n_hit;
    int n_fill;
    int n_evict;
    int n_inval_hit;
    int n_unused;
    int n_pid_writes;
    int stall_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // lowest-index valid entry holding the tag, or -1
    function automatic int find_slot(bit [fatlb_pkg::VPN_BITS-1:0] tag);
        for (int i = 0; i < fatlb_pkg::ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_tag[i] == tag)
                return i;
        end
        return -1;
    endfunction

    // expected result item of one request item; updates the shadow state
    function automatic fatlb_pkg::rsp_t translate_request(fatlb_pkg::req_t r);
        fatlb_pkg::rsp_t res;
        int              slot;
        res = '0;
        n_items++;
        case (r.op)
            fatlb_pkg::OP_LOOKUP:
            begin
                n_lookup++;
                if (r.pid == shadow_pid)
                begin
                    slot = find_slot(r.vpn);
                    if (slot >= 0)
                    begin
                        shadow_clock       = shadow_clock + 1'b1;
                        shadow_stamp[slot] = shadow_clock;
                        res.hit            = 1'b1;
                        res.phys_page      = shadow_frame[slot];
                        n_hit++;
                    end
                end
            end
            fatlb_pkg::OP_FILL:
            begin
                n_fill++;
                // first free entry, else lowest index with the oldest stamp
                slot = -1;
                for (int i = 0; i < fatlb_pkg::ENTRIES; i++)
                begin
                    if (!shadow_valid[i] && slot < 0)
                        slot = i;
                end
                if (slot < 0)
                begin
                    slot = 0;
                    for (int i = 1; i < fatlb_pkg::ENTRIES; i++)
                    begin
                        if (shadow_stamp[i] < shadow_stamp[slot])
                            slot = i;
                    end
                    n_evict++;
                end
                shadow_tag[slot]   = r.vpn;
                shadow_frame[slot] = r.ppn;
                shadow_valid[slot] = 1'b1;
                shadow_clock       = shadow_clock + 1'b1;
                shadow_stamp[slot] = shadow_clock;
            end
            fatlb_pkg::OP_INVAL:
            begin
                if (r.pid == shadow_pid)
                begin
                    slot = find_slot(r.vpn);
                    if (slot >= 0)
                    begin
                        shadow_valid[slot] = 1'b0;
                        n_inval_hit++;
                    end
                end
            end
            default:
                n_unused++;
        endcase
        return res;
    endfunction

    // random request item; mostly current pid and pooled page numbers
    function automatic fatlb_pkg::req_t random_request();
        fatlb_pkg::req_t r;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.op = fatlb_pkg::OP_LOOKUP;
        else if (pick < 80)
            r.op = fatlb_pkg::OP_FILL;
        else if (pick < 95)
            r.op = fatlb_pkg::OP_INVAL;
        else
            r.op = OP_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            r.pid = shadow_pid;
        else if (pick < 95)
            r.pid = shadow_pid
                    ^ (16'h1 << $urandom_range(0, fatlb_pkg::PID_BITS - 1));
        else
            r.pid = fatlb_pkg::PID_BITS'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.vpn = fatlb_pkg::VPN_BITS'($urandom);
        else
            r.vpn = vpn_pool[$urandom_range(0, pool_size - 1)];
        r.ppn = fatlb_pkg::PPN_BITS'($urandom);
        return r;
    endfunction

    task automatic queue_request(logic [fatlb_pkg::OP_BITS-1:0]  op,
                                 logic [fatlb_pkg::PID_BITS-1:0] pid,
                                 logic [fatlb_pkg::VPN_BITS-1:0] vpn,
                                 logic [fatlb_pkg::PPN_BITS-1:0] ppn);
        fatlb_pkg::req_t r;
        r.op  = op;
        r.pid = pid;
        r.vpn = vpn;
        r.ppn = ppn;
        send_q.push_back(r);
    endtask

    // current_pid write; only called with nothing in flight
    task automatic write_pid(logic [fatlb_pkg::PID_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_pid   = value;
        n_pid_writes++;
    endtask

    // wait until every item is sent and every result item has come back
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (send_q.size() != 0 || req_ch.valid || predicted_xlat.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // request driver with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.op    <= fatlb_pkg::OP_LOOKUP;
            req_ch.pid   <= '0;
            req_ch.vpn   <= '0;
            req_ch.ppn   <= '0;
            send_gap     <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (send_q.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                send_gap     <= $urandom_range(0, 18);
                req_ch.valid <= 1'b0;
            end
            else
            begin
                next_req      = send_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.op    <= next_req.op;
                req_ch.pid   <= next_req.pid;
                req_ch.vpn   <= next_req.vpn;
                req_ch.ppn   <= next_req.ppn;
            end
        end
    end

    // result receiver: random stalls and one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= 0;
            hold_left    <= 0;
            hold_seen    <= 1'b0;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen    <= hold_trigger;
            hold_left    <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_gap != 0)
        begin
            rsp_gap      <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            rsp_gap      <= $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: check result items first, then predict accepted request items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_xlat.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result item hit=%0b phys_page=%05h",
                             $realtime, rsp_ch.hit, rsp_ch.phys_page);
                end
                else
                begin
                    want = predicted_xlat.pop_front();
                    if (rsp_ch.hit !== want.hit)
                    begin
                        error_count++;
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $realtime, want.hit, rsp_ch.hit);
                    end
                    if (rsp_ch.phys_page !== want.phys_page)
                    begin
                        error_count++;
                        $display("%0t: phys_page mismatch, expected %05h actual %05h",
                                 $realtime, want.phys_page, rsp_ch.phys_page);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.op  = req_ch.op;
                seen_req.pid = req_ch.pid;
                seen_req.vpn = req_ch.vpn;
                seen_req.ppn = req_ch.ppn;
                predicted_xlat.push_back(translate_request(seen_req));
            end
        end
    end

    // watchdog: too long without any item moving on either channel
    initial
    begin
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, predicted_xlat.size());
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.op     = fatlb_pkg::OP_LOOKUP;
        req_ch.pid    = '0;
        req_ch.vpn    = '0;
        req_ch.ppn    = '0;
        rsp_ch.ready  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        gaps_on       = 1'b1;
        hold_trigger  = 1'b0;
        pool_size     = 1;
        shadow_clock  = '0;
        shadow_pid    = '0;
        for (int i = 0; i < fatlb_pkg::ENTRIES; i++)
            shadow_valid[i] = 1'b0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed sequence on an empty tlb
        write_pid(16'hA5C3);
        @(negedge clk);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'h00000, 20'h00000);
        // fill ignores pid; extremes of vpn and ppn
        queue_request(fatlb_pkg::OP_FILL,   16'h0000, 20'hFFFFF, 20'hFFFFF);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'hFFFFF, 20'h00000);
        // pid mismatch on lookup
        queue_request(fatlb_pkg::OP_LOOKUP, 16'h5A3C, 20'hFFFFF, 20'hFFFFF);
        queue_request(fatlb_pkg::OP_FILL,   16'hFFFF, 20'h00000, 20'h00000);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'h00000, 20'hFFFFF);
        // duplicate fill; lookup must return the lower entry
        queue_request(fatlb_pkg::OP_FILL,   16'hA5C3, 20'h12345, 20'hABCDE);
        queue_request(fatlb_pkg::OP_FILL,   16'hA5C3, 20'h12345, 20'h54321);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'h12345, 20'h00000);
        // pid mismatch on invalidate, then a real invalidate
        queue_request(fatlb_pkg::OP_INVAL,  16'h5A3C, 20'h12345, 20'h00000);
        queue_request(fatlb_pkg::OP_INVAL,  16'hA5C3, 20'h12345, 20'h00000);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'h12345, 20'h00000);
        // invalidate with no match, unused op
        queue_request(fatlb_pkg::OP_INVAL,  16'hA5C3, 20'h77777, 20'h00000);
        queue_request(OP_NONE,              16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        // refill the freed entry
        queue_request(fatlb_pkg::OP_FILL,   16'h1234, 20'h00001, 20'h80000);
        queue_request(fatlb_pkg::OP_LOOKUP, 16'hA5C3, 20'h00001, 20'h00000);
        wait_until_drained();

        // random phases; the last one runs without gaps
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_pid(16'hFFFF);
                1:       write_pid(16'h0000);
                default: write_pid(fatlb_pkg::PID_BITS'($urandom_range(0, 65535)));
            endcase
            // small pools give many hits, large pools keep evicting
            pool_size   = (phase % 2 == 0) ? 40 : 10;
            vpn_pool[0] = '0;
            vpn_pool[1] = '1;
            for (int i = 2; i < pool_size; i++)
                vpn_pool[i] = fatlb_pkg::VPN_BITS'($urandom);
            @(negedge clk);
            gaps_on = (phase != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_q.push_back(random_request());
            if (phase == 3)
                hold_trigger = ~hold_trigger;
            wait_until_drained();
        end

        repeat (30) @(posedge clk);
        if (predicted_xlat.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d result items never arrived", $realtime, predicted_xlat.size());
        end

        $display("ran %0d request items under %0d pid settings: %0d lookups (%0d hits),",
                 n_items, n_pid_writes, n_lookup, n_hit);
        $display("%0d fills (%0d evictions), %0d invalidations, %0d unused ops; %0d errors",
                 n_fill, n_evict, n_inval_hit, n_unused, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fatlb_pkg.sv
hw/rtl/fatlb_if.sv
hw/rtl/fatlb_ram.sv
hw/rtl/fatlb_scan.sv
hw/rtl/fully_associative_tlb_lru_top.sv
tb/fully_associative_tlb_lru_top_test.sv
